FILE: rtl/core/button_click_count_and_hold_detector_macros.svh
// Assertion macros used by the checker file of the click and hold detector.
// No dependencies; include with the bare file name.
`ifndef BUTTON_CLICK_COUNT_AND_HOLD_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_COUNT_AND_HOLD_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCCD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCCD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/bccd_pkg.sv
// Package for the click and hold detector: widths, codes, reset values and types.
// No dependencies; all other SystemVerilog files but the macro header use it by scoped names.
package bccd_pkg;

   localparam int BUTTONS     = 4;
   localparam int CMD_W       = 2;
   localparam int BUTTON_W    = 2;
   localparam int TIME_W      = 32;
   localparam int MS_W        = 16;
   localparam int COUNT_W     = 8;
   localparam int LEVEL_W     = 2;
   localparam int MARK_W      = MS_W + 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SCAN    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CLICK_GAP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD_UNIT     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_CLICKS    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESSED_LEVEL = 3'd4;

   localparam logic [MS_W-1:0]    DEBOUNCE_RESET  = 16'd50;
   localparam logic [MS_W-1:0]    CLICK_GAP_RESET = 16'd400;
   localparam logic [MS_W-1:0]    HOLD_UNIT_RESET = 16'd1000;
   localparam logic [COUNT_W-1:0] MAX_CLICKS_RESET = 8'd5;
   localparam logic               PRESSED_LEVEL_RESET = 1'b0;

   localparam logic KIND_CLICK = 1'b0;
   localparam logic KIND_HOLD  = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_TOP = 2'd3;

   typedef enum logic [1:0] {
      OP_PRESS,
      OP_RELEASE,
      OP_SCAN
   } op_type;

   typedef struct packed {
      logic [MS_W-1:0]    debounce_ms;
      logic [MS_W-1:0]    click_gap_ms;
      logic [MS_W-1:0]    hold_unit_ms;
      logic [COUNT_W-1:0] max_clicks;
      logic               pressed_level;
   } cfg_type;

   typedef struct packed {
      op_type              op;
      logic [BUTTON_W-1:0] button;
      logic                pressed;
      logic [TIME_W-1:0]   now_ms;
   } entry_type;

   typedef struct packed {
      logic [BUTTON_W-1:0] which_button;
      logic                report_kind;
      logic [COUNT_W-1:0]  amount;
      logic                keep_scanning;
   } rsp_type;

endpackage

FILE: rtl/core/bccd_if.sv
// Channel interfaces of the click and hold detector: scan requests, reports, register writes.
// Depends on bccd_pkg for field widths.
interface bccd_req_if;
   logic                          valid;
   logic                          ready;
   logic [bccd_pkg::CMD_W-1:0]    cmd;
   logic [bccd_pkg::BUTTON_W-1:0] button;
   logic                          pin_level;
   logic [bccd_pkg::TIME_W-1:0]   now_ms;

   modport source (output valid, cmd, button, pin_level, now_ms, input ready);
   modport sink (input valid, cmd, button, pin_level, now_ms, output ready);
endinterface

interface bccd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bccd_pkg::BUTTON_W-1:0] which_button;
   logic                          report_kind;
   logic [bccd_pkg::COUNT_W-1:0]  amount;
   logic                          keep_scanning;

   modport source (output valid, which_button, report_kind, amount, keep_scanning,
                   input ready);
   modport sink (input valid, which_button, report_kind, amount, keep_scanning,
                 output ready);
endinterface

interface bccd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bccd_pkg::CSR_INDEX_W-1:0] index;
   logic [bccd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/button_click_count_and_hold_detector.sv
// Multi-click and long-press detector for four buttons. It accepts one request transfer
// per clock cycle while the queue has room and answers a scan with at most one report:
// the front end decodes the request into a two-entry queue, and the back end reads,
// updates and writes the selected button's state and registers any report, taking one
// item per cycle while the output register is empty or being read. A report waits there
// while new requests keep flowing until the queue fills. Configuration writes complete in
// the cycle they are presented and should be made while no request is in flight.
module button_click_count_and_hold_detector (
   input  logic       clock,
   input  logic       reset,
   bccd_req_if.sink   req_bus,
   bccd_rsp_if.source rsp_bus,
   bccd_csr_if.sink   csr_bus
);

   bccd_pkg::cfg_type   cfg;
   logic                push_valid, push_ready;
   bccd_pkg::entry_type push_data;
   logic                pop_valid, pop_ready;
   bccd_pkg::entry_type pop_data;

   bccd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   bccd_front u_front (
      .req_bus       (req_bus),
      .pressed_level (cfg.pressed_level),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   bccd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bccd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .item      (pop_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: rtl/core/bccd_csr.sv
// Configuration registers of the click and hold detector.
// Depends on bccd_pkg and the write channel interface in bccd_if.
module bccd_csr (
   input  logic              clock,
   input  logic              reset,
   bccd_csr_if.sink          csr_bus,
   output bccd_pkg::cfg_type cfg
);

   bccd_pkg::cfg_type cfg_ff;
   bccd_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            bccd_pkg::REG_DEBOUNCE:      cfg_in.debounce_ms = csr_bus.data;
            bccd_pkg::REG_CLICK_GAP:     cfg_in.click_gap_ms = csr_bus.data;
            bccd_pkg::REG_HOLD_UNIT:     cfg_in.hold_unit_ms = csr_bus.data;
            bccd_pkg::REG_MAX_CLICKS:    cfg_in.max_clicks = csr_bus.data[bccd_pkg::COUNT_W-1:0];
            bccd_pkg::REG_PRESSED_LEVEL: cfg_in.pressed_level = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= bccd_pkg::DEBOUNCE_RESET;
         cfg_ff.click_gap_ms  <= bccd_pkg::CLICK_GAP_RESET;
         cfg_ff.hold_unit_ms  <= bccd_pkg::HOLD_UNIT_RESET;
         cfg_ff.max_clicks    <= bccd_pkg::MAX_CLICKS_RESET;
         cfg_ff.pressed_level <= bccd_pkg::PRESSED_LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/bccd_front.sv
// Front end: accepts request transfers, decodes the command and drops items without effect.
// Depends on bccd_pkg and the request interface in bccd_if.
module bccd_front (
   bccd_req_if.sink              req_bus,
   input  logic                  pressed_level,
   output logic                  push_valid,
   input  logic                  push_ready,
   output bccd_pkg::entry_type   push_data
);

   logic keep;

   assign req_bus.ready = push_ready;

   always_comb begin
      keep = 1'b1;
      push_data.op = bccd_pkg::OP_SCAN;
      unique case (req_bus.cmd)
         bccd_pkg::CMD_PRESS:   push_data.op = bccd_pkg::OP_PRESS;
         bccd_pkg::CMD_RELEASE: push_data.op = bccd_pkg::OP_RELEASE;
         bccd_pkg::CMD_SCAN:    push_data.op = bccd_pkg::OP_SCAN;
         default:               keep = 1'b0;
      endcase
      if (32'(req_bus.button) >= 32'(bccd_pkg::BUTTONS)) begin
         keep = 1'b0;
      end
      push_data.button  = req_bus.button;
      push_data.pressed = (req_bus.pin_level == pressed_level);
      push_data.now_ms  = req_bus.now_ms;
      push_valid = req_bus.valid && keep;
   end

endmodule

FILE: rtl/core/bccd_fifo.sv
// Short queue between the front end and the back end of the click and hold detector.
// Depends on bccd_pkg for the entry type and depth.
module bccd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  bccd_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output bccd_pkg::entry_type pop_data
);

   bccd_pkg::entry_type                 entries_ff [bccd_pkg::QUEUE_DEPTH];
   logic [bccd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [bccd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [bccd_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                                do_push, do_pop;

   localparam logic [bccd_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      bccd_pkg::QUEUE_PTR_W'(bccd_pkg::QUEUE_DEPTH - 1);
   localparam logic [bccd_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      bccd_pkg::QUEUE_CNT_W'(bccd_pkg::QUEUE_DEPTH);

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push_valid && push_ready;
      do_pop    = pop_valid && pop_ready;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/bccd_back.sv
// Back end: per-button press, release and scan handling and the report output register.
// Depends on bccd_pkg and the report interface in bccd_if.
module bccd_back (
   input  logic                clock,
   input  logic                reset,
   input  bccd_pkg::cfg_type   cfg,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  bccd_pkg::entry_type item,
   bccd_rsp_if.source          rsp_bus
);

   logic [bccd_pkg::TIME_W-1:0]  press_time_ff  [bccd_pkg::BUTTONS];
   logic [bccd_pkg::TIME_W-1:0]  press_time_in  [bccd_pkg::BUTTONS];
   logic [bccd_pkg::COUNT_W-1:0] press_count_ff [bccd_pkg::BUTTONS];
   logic [bccd_pkg::COUNT_W-1:0] press_count_in [bccd_pkg::BUTTONS];
   logic                         holding_ff     [bccd_pkg::BUTTONS];
   logic                         holding_in     [bccd_pkg::BUTTONS];
   logic [bccd_pkg::LEVEL_W-1:0] hold_level_ff  [bccd_pkg::BUTTONS];
   logic [bccd_pkg::LEVEL_W-1:0] hold_level_in  [bccd_pkg::BUTTONS];

   logic                rsp_valid_ff, rsp_valid_in;
   bccd_pkg::rsp_type   rsp_data_ff;
   bccd_pkg::rsp_type   emit_data;
   logic                emit;
   logic                fire;

   logic [bccd_pkg::TIME_W-1:0]  cur_time, new_time, elapsed;
   logic [bccd_pkg::COUNT_W-1:0] cur_count, new_count;
   logic                         cur_hold, new_hold;
   logic [bccd_pkg::LEVEL_W-1:0] cur_level, new_level, next_level;
   logic [bccd_pkg::MARK_W-1:0]  mark;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.which_button  = rsp_data_ff.which_button;
   assign rsp_bus.report_kind   = rsp_data_ff.report_kind;
   assign rsp_bus.amount        = rsp_data_ff.amount;
   assign rsp_bus.keep_scanning = rsp_data_ff.keep_scanning;

   always_comb begin
      pop_ready = !rsp_valid_ff || rsp_bus.ready;
      fire      = pop_valid && pop_ready;

      cur_time  = press_time_ff[item.button];
      cur_count = press_count_ff[item.button];
      cur_hold  = holding_ff[item.button];
      cur_level = hold_level_ff[item.button];
      elapsed   = item.now_ms - cur_time;
      next_level = cur_level + 1'b1;

      case (cur_level)
         2'd0:    mark = {2'b00, cfg.hold_unit_ms};
         2'd1:    mark = {1'b0, cfg.hold_unit_ms, 1'b0};
         2'd2:    mark = {2'b00, cfg.hold_unit_ms} + {1'b0, cfg.hold_unit_ms, 1'b0};
         default: mark = '1;
      endcase

      new_time  = cur_time;
      new_count = cur_count;
      new_hold  = cur_hold;
      new_level = cur_level;
      emit      = 1'b0;
      emit_data.which_button  = item.button;
      emit_data.report_kind   = bccd_pkg::KIND_HOLD;
      emit_data.amount        = {{(bccd_pkg::COUNT_W - bccd_pkg::LEVEL_W){1'b0}}, next_level};
      emit_data.keep_scanning = 1'b1;

      if (fire) begin
         unique case (item.op)
            bccd_pkg::OP_PRESS: begin
               new_time  = item.now_ms;
               new_count = (cur_count != bccd_pkg::COUNT_MAX) ? cur_count + 1'b1 : cur_count;
               new_level = '0;
            end
            bccd_pkg::OP_RELEASE: begin
               if (elapsed <= {16'd0, cfg.debounce_ms} && cur_count != '0) begin
                  new_count = cur_count - 1'b1;
               end
            end
            bccd_pkg::OP_SCAN: begin
               if (cur_count != '0) begin
                  if (item.pressed) begin
                     if (cur_level != bccd_pkg::LEVEL_TOP &&
                         elapsed >= {14'd0, mark}) begin
                        new_level = next_level;
                        new_hold  = 1'b1;
                        emit      = 1'b1;
                     end
                  end else if (!cur_hold) begin
                     if (elapsed >= {16'd0, cfg.click_gap_ms}) begin
                        new_count = '0;
                        new_level = '0;
                        emit_data.report_kind   = bccd_pkg::KIND_CLICK;
                        emit_data.amount        = cur_count;
                        emit_data.keep_scanning = 1'b0;
                        emit = (cur_count <= cfg.max_clicks);
                     end
                  end else begin
                     new_hold  = 1'b0;
                     new_count = '0;
                     new_level = '0;
                  end
               end
            end
            default: ;
         endcase
      end

      press_time_in  = press_time_ff;
      press_count_in = press_count_ff;
      holding_in     = holding_ff;
      hold_level_in  = hold_level_ff;
      press_time_in[item.button]  = new_time;
      press_count_in[item.button] = new_count;
      holding_in[item.button]     = new_hold;
      hold_level_in[item.button]  = new_level;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < bccd_pkg::BUTTONS; i++) begin
            press_time_ff[i]  <= '0;
            press_count_ff[i] <= '0;
            holding_ff[i]     <= 1'b0;
            hold_level_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         press_time_ff  <= press_time_in;
         press_count_ff <= press_count_in;
         holding_ff     <= holding_in;
         hold_level_ff  <= hold_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

endmodule

FILE: rtl/core/bccd_checker.sv
// Port-level checks of the click and hold detector and the bind that attaches them.
// Depends on bccd_pkg and button_click_count_and_hold_detector_macros.svh.
`include "button_click_count_and_hold_detector_macros.svh"

module bccd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bccd_pkg::BUTTON_W-1:0] rsp_which_button,
   input logic                          rsp_report_kind,
   input logic [bccd_pkg::COUNT_W-1:0]  rsp_amount,
   input logic                          rsp_keep_scanning
);

   logic [bccd_pkg::BUTTON_W+bccd_pkg::COUNT_W+1:0] rsp_payload;

   assign rsp_payload = {rsp_which_button, rsp_report_kind, rsp_amount, rsp_keep_scanning};

   `BCCD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "Stalled report transfer changed.")
   `BCCD_ASSERT_IMP(a_hold_report, clock, reset, rsp_valid && rsp_report_kind == bccd_pkg::KIND_HOLD, rsp_amount >= 8'd1 && rsp_amount <= 8'd3 && rsp_keep_scanning, "Hold report has a bad level or clears scanning.")
   `BCCD_ASSERT_IMP(a_click_report, clock, reset, rsp_valid && rsp_report_kind == bccd_pkg::KIND_CLICK, rsp_amount != 8'd0 && !rsp_keep_scanning, "Click report has zero count or keeps scanning.")
   `BCCD_ASSERT_IMP(a_reset_quiet, clock, reset, $past(reset), !rsp_valid, "Report valid right after reset.")

endmodule

bind button_click_count_and_hold_detector bccd_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_which_button  (rsp_bus.which_button),
   .rsp_report_kind   (rsp_bus.report_kind),
   .rsp_amount        (rsp_bus.amount),
   .rsp_keep_scanning (rsp_bus.keep_scanning)
);

FILE: sim/tb_button_click_count_and_hold_detector.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-click and long-press detector: it drives press, release, scan
// and unused-command transfers under random idling and report stalls and checks each report in order
// against a predictor kept here. It depends on bccd_pkg, the bccd channel interfaces and the RTL.
module tb_button_click_count_and_hold_detector;

   localparam logic [bccd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RANDOM_ITEMS = 1240;
   localparam int unsigned PHASES = 8;

   logic clock;
   logic reset;

   bccd_req_if req_bus();
   bccd_rsp_if rsp_bus();
   bccd_csr_if csr_bus();

   button_click_count_and_hold_detector i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   bccd_pkg::cfg_type            cfg;
   logic [bccd_pkg::TIME_W-1:0]  press_time [bccd_pkg::BUTTONS];
   logic [bccd_pkg::COUNT_W-1:0] press_count [bccd_pkg::BUTTONS];
   logic                         holding [bccd_pkg::BUTTONS];
   logic [bccd_pkg::LEVEL_W-1:0] hold_level [bccd_pkg::BUTTONS];
   bccd_pkg::rsp_type            pending_reports [$];
   bccd_pkg::rsp_type            want;

   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned hold_reports = 0;
   int unsigned click_reports = 0;
   int unsigned settings_run = 0;
   int unsigned ready_stall = 0;
   logic [bccd_pkg::TIME_W-1:0] clock_ms = '0;
   bit calm = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void clear_tracker();
      cfg.debounce_ms = bccd_pkg::DEBOUNCE_RESET;
      cfg.click_gap_ms = bccd_pkg::CLICK_GAP_RESET;
      cfg.hold_unit_ms = bccd_pkg::HOLD_UNIT_RESET;
      cfg.max_clicks = bccd_pkg::MAX_CLICKS_RESET;
      cfg.pressed_level = bccd_pkg::PRESSED_LEVEL_RESET;
      for (int i = 0; i < bccd_pkg::BUTTONS; i++) begin
         press_time[i] = '0;
         press_count[i] = '0;
         holding[i] = 1'b0;
         hold_level[i] = '0;
      end
   endfunction

   function automatic void apply_write(logic [bccd_pkg::CSR_INDEX_W-1:0] index,
                                       logic [bccd_pkg::CSR_DATA_W-1:0] data);
      case (index)
         bccd_pkg::REG_DEBOUNCE: cfg.debounce_ms = data;
         bccd_pkg::REG_CLICK_GAP: cfg.click_gap_ms = data;
         bccd_pkg::REG_HOLD_UNIT: cfg.hold_unit_ms = data;
         bccd_pkg::REG_MAX_CLICKS: cfg.max_clicks = data[bccd_pkg::COUNT_W-1:0];
         bccd_pkg::REG_PRESSED_LEVEL: cfg.pressed_level = data[0];
         default: ;
      endcase
   endfunction

   // Updates one button's state for an accepted transfer and queues the report it causes.
   function automatic void track_button(logic [bccd_pkg::CMD_W-1:0] cmd,
                                        logic [bccd_pkg::BUTTON_W-1:0] b,
                                        logic level, logic [bccd_pkg::TIME_W-1:0] now);
      logic [bccd_pkg::TIME_W-1:0]  elapsed;
      logic [bccd_pkg::TIME_W-1:0]  mark_ms;
      logic [bccd_pkg::LEVEL_W:0]   next_mark;
      bccd_pkg::rsp_type            rep;
      elapsed = now - press_time[b];
      next_mark = hold_level[b] + 1'b1;
      mark_ms = bccd_pkg::TIME_W'(next_mark) * bccd_pkg::TIME_W'(cfg.hold_unit_ms);
      rep.which_button = b;
      if (cmd == bccd_pkg::CMD_PRESS) begin
         press_time[b] = now;
         if (press_count[b] != bccd_pkg::COUNT_MAX) press_count[b] = press_count[b] + 1'b1;
         hold_level[b] = '0;
      end else if (cmd == bccd_pkg::CMD_RELEASE) begin
         if (elapsed <= bccd_pkg::TIME_W'(cfg.debounce_ms) && press_count[b] != 0)
            press_count[b] = press_count[b] - 1'b1;
      end else if (cmd == bccd_pkg::CMD_SCAN && press_count[b] != 0) begin
         if (level == cfg.pressed_level) begin
            if (next_mark <= bccd_pkg::LEVEL_TOP && elapsed >= mark_ms) begin
               hold_level[b] = next_mark[bccd_pkg::LEVEL_W-1:0];
               holding[b] = 1'b1;
               rep.report_kind = bccd_pkg::KIND_HOLD;
               rep.amount = bccd_pkg::COUNT_W'(next_mark);
               rep.keep_scanning = 1'b1;
               pending_reports.push_back(rep);
            end
         end else if (!holding[b]) begin
            if (elapsed >= bccd_pkg::TIME_W'(cfg.click_gap_ms)) begin
               rep.amount = press_count[b];
               press_count[b] = '0;
               hold_level[b] = '0;
               if (rep.amount <= cfg.max_clicks) begin
                  rep.report_kind = bccd_pkg::KIND_CLICK;
                  rep.keep_scanning = 1'b0;
                  pending_reports.push_back(rep);
               end
            end
         end else begin
            holding[b] = 1'b0;
            press_count[b] = '0;
            hold_level[b] = '0;
         end
      end
   endfunction

   task automatic send_item(logic [bccd_pkg::CMD_W-1:0] cmd,
                            logic [bccd_pkg::BUTTON_W-1:0] b, logic level,
                            logic [bccd_pkg::TIME_W-1:0] now);
      int unsigned gap;
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.button <= b;
      req_bus.pin_level <= level;
      req_bus.now_ms <= now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      track_button(cmd, b, level, now);
      if (cmd != CMD_UNUSED) items_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Requests that cause no report may still be in the pipeline after the last report.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [bccd_pkg::CSR_INDEX_W-1:0] index,
                            logic [bccd_pkg::CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      apply_write(index, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_config(bccd_pkg::cfg_type c);
      settle();
      write_reg(bccd_pkg::REG_DEBOUNCE, c.debounce_ms);
      write_reg(bccd_pkg::REG_CLICK_GAP, c.click_gap_ms);
      write_reg(bccd_pkg::REG_HOLD_UNIT, c.hold_unit_ms);
      write_reg(bccd_pkg::REG_MAX_CLICKS, {8'($urandom), c.max_clicks});
      write_reg(bccd_pkg::REG_PRESSED_LEVEL, {15'($urandom), c.pressed_level});
      settings_run++;
   endtask

   function automatic bccd_pkg::cfg_type default_setting();
      bccd_pkg::cfg_type c;
      c.debounce_ms = bccd_pkg::DEBOUNCE_RESET;
      c.click_gap_ms = bccd_pkg::CLICK_GAP_RESET;
      c.hold_unit_ms = bccd_pkg::HOLD_UNIT_RESET;
      c.max_clicks = bccd_pkg::MAX_CLICKS_RESET;
      c.pressed_level = bccd_pkg::PRESSED_LEVEL_RESET;
      return c;
   endfunction

   function automatic bccd_pkg::cfg_type pick_setting(int phase);
      bccd_pkg::cfg_type c;
      c.debounce_ms = bccd_pkg::MS_W'($urandom_range(0, 300));
      c.click_gap_ms = bccd_pkg::MS_W'($urandom_range(0, 1000));
      c.hold_unit_ms = bccd_pkg::MS_W'($urandom_range(1, 2000));
      c.max_clicks = bccd_pkg::COUNT_W'($urandom_range(1, 8));
      c.pressed_level = 1'($urandom_range(0, 1));
      case (phase)
         0: c = '{16'd0, 16'd0, 16'd1, 8'd1, 1'b1};
         1: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, bccd_pkg::COUNT_MAX, 1'b0};
         2: c = default_setting();
         3: c.hold_unit_ms = '0;
         4: c = '{16'hFFFF, 16'd0, 16'd1, bccd_pkg::COUNT_MAX, 1'b1};
         default: ;
      endcase
      return c;
   endfunction

   task automatic test_directed_edges();
      send_item(bccd_pkg::CMD_PRESS, 2'd0, 1'b0, 32'd1000);
      send_item(bccd_pkg::CMD_RELEASE, 2'd0, 1'b1, 32'd1020);
      send_item(bccd_pkg::CMD_RELEASE, 2'd0, 1'b1, 32'd1030);
      send_item(bccd_pkg::CMD_SCAN, 2'd0, 1'b1, 32'd1040);
      send_item(bccd_pkg::CMD_PRESS, 2'd1, 1'b0, 32'd2000);
      send_item(bccd_pkg::CMD_RELEASE, 2'd1, 1'b1, 32'd2100);
      send_item(bccd_pkg::CMD_PRESS, 2'd1, 1'b0, 32'd2300);
      send_item(bccd_pkg::CMD_RELEASE, 2'd1, 1'b1, 32'd2400);
      send_item(bccd_pkg::CMD_SCAN, 2'd1, 1'b1, 32'd2500);
      send_item(bccd_pkg::CMD_SCAN, 2'd1, 1'b1, 32'd2700);
      send_item(bccd_pkg::CMD_PRESS, 2'd2, 1'b0, 32'hFFFF_FF00);
      send_item(bccd_pkg::CMD_SCAN, 2'd2, 1'b0, 32'h0000_0400);
      send_item(bccd_pkg::CMD_SCAN, 2'd2, 1'b0, 32'h0000_1000);
      send_item(bccd_pkg::CMD_SCAN, 2'd2, 1'b0, 32'h0000_1000);
      send_item(bccd_pkg::CMD_SCAN, 2'd2, 1'b0, 32'h0000_1000);
      send_item(bccd_pkg::CMD_SCAN, 2'd2, 1'b1, 32'h0000_1010);
      send_item(bccd_pkg::CMD_SCAN, 2'd2, 1'b1, 32'h0000_2000);
      send_item(CMD_UNUSED, 2'd3, 1'b0, 32'd3000);
      send_item(bccd_pkg::CMD_PRESS, 2'd3, 1'b0, 32'd5000);
      send_item(bccd_pkg::CMD_RELEASE, 2'd3, 1'b1, 32'd5060);
      send_item(bccd_pkg::CMD_SCAN, 2'd3, 1'b0, 32'd5100);
      send_item(bccd_pkg::CMD_SCAN, 2'd3, 1'b1, 32'd5400);
   endtask

   task automatic test_zero_hold_unit();
      bccd_pkg::cfg_type c;
      c = default_setting();
      c.hold_unit_ms = '0;
      write_config(c);
      send_item(bccd_pkg::CMD_PRESS, 2'd1, 1'b0, 32'd100);
      repeat (4) send_item(bccd_pkg::CMD_SCAN, 2'd1, 1'b0, 32'd100);
      send_item(bccd_pkg::CMD_SCAN, 2'd1, 1'b1, 32'd600);
   endtask

   task automatic test_press_saturation();
      bccd_pkg::cfg_type c;
      c = default_setting();
      c.max_clicks = bccd_pkg::COUNT_MAX;
      write_config(c);
      repeat (256) send_item(bccd_pkg::CMD_PRESS, 2'd3, 1'b0, 32'd7000);
      send_item(bccd_pkg::CMD_SCAN, 2'd3, 1'b1, 32'd7400);
   endtask

   task automatic run_gesture();
      logic [bccd_pkg::BUTTON_W-1:0] b;
      logic                          down;
      int unsigned                   unit_ms;
      b = bccd_pkg::BUTTON_W'($urandom_range(0, bccd_pkg::BUTTONS - 1));
      down = cfg.pressed_level;
      unit_ms = (cfg.hold_unit_ms == 0) ? 1 : cfg.hold_unit_ms;
      repeat ($urandom_range(1, 6)) begin
         send_item(bccd_pkg::CMD_PRESS, b, down, clock_ms);
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               clock_ms += $urandom_range(unit_ms / 2, unit_ms + unit_ms / 2);
               send_item(bccd_pkg::CMD_SCAN, b, down, clock_ms);
            end
         end else if ($urandom_range(0, 2) == 0) begin
            clock_ms += $urandom_range(0, unit_ms);
            send_item(bccd_pkg::CMD_SCAN, b, down, clock_ms);
         end
         if ($urandom_range(0, 3) == 0) clock_ms += $urandom_range(0, cfg.debounce_ms);
         else clock_ms += cfg.debounce_ms + $urandom_range(1, 300);
         send_item(bccd_pkg::CMD_RELEASE, b, ~down, clock_ms);
         if ($urandom_range(0, 1) == 0) begin
            clock_ms += $urandom_range(0, cfg.click_gap_ms);
            send_item(bccd_pkg::CMD_SCAN, b, ~down, clock_ms);
         end
      end
      if ($urandom_range(0, 3) == 0) clock_ms += $urandom_range(0, cfg.click_gap_ms);
      else clock_ms += cfg.click_gap_ms + $urandom_range(0, 200);
      send_item(bccd_pkg::CMD_SCAN, b, ~down, clock_ms);
   endtask

   task automatic test_random_gestures();
      int unsigned quota;
      for (int p = 0; p < PHASES; p++) begin
         write_config(pick_setting(p));
         calm = (p % 3 == 2);
         clock_ms = $urandom();
         quota = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < quota) begin
            if ($urandom_range(0, 6) == 0)
               send_item(bccd_pkg::CMD_W'($urandom_range(0, 3)),
                         bccd_pkg::BUTTON_W'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), $urandom());
            else
               run_gesture();
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (ready_stall == 0 && !calm && $urandom_range(0, 3) == 0) ready_stall = pick_gap();
         if (ready_stall != 0) begin
            rsp_bus.ready <= 1'b0;
            ready_stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected report transfer: which_button %0d report_kind %0d amount %0d",
                   rsp_bus.which_button, rsp_bus.report_kind, rsp_bus.amount);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (want.report_kind == bccd_pkg::KIND_HOLD) hold_reports++;
            else click_reports++;
            if (rsp_bus.which_button !== want.which_button) begin
               $error("which_button: expected %0d, actual %0d", want.which_button,
                      rsp_bus.which_button);
               error_count++;
            end
            if (rsp_bus.report_kind !== want.report_kind) begin
               $error("report_kind: expected %0d, actual %0d", want.report_kind,
                      rsp_bus.report_kind);
               error_count++;
            end
            if (rsp_bus.amount !== want.amount) begin
               $error("amount: expected %0d, actual %0d", want.amount, rsp_bus.amount);
               error_count++;
            end
            if (rsp_bus.keep_scanning !== want.keep_scanning) begin
               $error("keep_scanning: expected %0d, actual %0d", want.keep_scanning,
                      rsp_bus.keep_scanning);
               error_count++;
            end
         end
      end
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timed out after %0d cycles.", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= bccd_pkg::CMD_PRESS;
      req_bus.button <= '0;
      req_bus.pin_level <= 1'b0;
      req_bus.now_ms <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= bccd_pkg::REG_DEBOUNCE;
      csr_bus.data <= '0;
      clear_tracker();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_zero_hold_unit();
      test_press_saturation();
      test_random_gestures();
      settle();
      $display("Sent %0d request transfers over %0d register settings.", items_sent,
               settings_run);
      $display("Checked %0d click reports and %0d hold reports.", click_reports, hold_reports);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/bccd_pkg.sv
rtl/core/bccd_if.sv
rtl/core/bccd_csr.sv
rtl/core/bccd_front.sv
rtl/core/bccd_fifo.sv
rtl/core/bccd_back.sv
rtl/core/button_click_count_and_hold_detector.sv
rtl/core/bccd_checker.sv
sim/tb_button_click_count_and_hold_detector.sv
